/* sv/cleb_pkg.sv */
// shared types and constants for the cursor line edit buffer
// no dependencies; imported by the top, controller, datapath and testbench
package cleb_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0] KEY_HOME  = 8'h5B;  // '['
  localparam logic [7:0] KEY_END   = 8'h5D;  // ']'
  localparam logic [7:0] KEY_DEL   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] KEY_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] KEY_NL    = 8'h0A;  // newline

  typedef enum logic [1:0] {
    K_SIMPLE,
    K_READ,
    K_INSERT,
    K_DELETE
  } cleb_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_INS,
    S_INS_FIN,
    S_DEL,
    S_DONE
  } cleb_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic ins_step;
    logic ins_fin;
    logic del_step;
    logic del_fin;
    logic rd_cap;
    logic out_load;
  } cleb_cmd_t;

  typedef struct packed {
    cleb_kind_t kind;
    logic       ins_done;
    logic       del_done;
  } cleb_stat_t;

endpackage

/* sv/cursor_line_edit_buffer_top.sv */
// top level of the cursor line edit buffer
// uses cleb_pkg, cleb_ctrl and cleb_dp
//
// Line edit buffer of BUF_DEPTH bytes with a cursor. One item is in work at a
// time. Cursor moves, newline, clear, refused edits and reads need no walk;
// an insert or a delete moves every character behind the cursor one place
// through the single write port of the text memory, one character per cycle.
// A new item is taken while the previous result still waits in the output
// register.
module cursor_line_edit_buffer_top
  import cleb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_key,
  input  logic [ADDR_W-1:0] in_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic [7:0]        out_char_out,
  output logic [CNT_W-1:0]  out_length,
  output logic [CNT_W-1:0]  out_cursor
);

  cleb_cmd_t  cmd;
  cleb_stat_t stat;

  cleb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cleb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_func),
    .in_key       (in_key),
    .in_index     (in_index),
    .out_ok       (out_ok),
    .out_char_out (out_char_out),
    .out_length   (out_length),
    .out_cursor   (out_cursor)
  );

endmodule

/* sv/cleb_ram.sv */
// generic single write port, single read port ram with registered read
// no package dependency
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/cleb_ctrl.sv */
// controller state machine for the line edit buffer
// uses cleb_pkg; drives the datapath by command struct, reads its status
module cleb_ctrl
  import cleb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  cleb_stat_t stat,
  output cleb_cmd_t  cmd
);

  cleb_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.kind)
          K_READ:   state_nxt = S_RD;
          K_INSERT: state_nxt = S_INS;
          K_DELETE: state_nxt = S_DEL;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_RD:      state_nxt = S_DONE;
      S_INS: begin
        if (stat.ins_done) begin
          state_nxt = S_INS_FIN;
        end
      end
      S_INS_FIN: state_nxt = S_DONE;
      S_DEL: begin
        if (stat.del_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:    cmd.latch    = in_valid;
      S_EXEC:    cmd.exec     = 1'b1;
      S_RD:      cmd.rd_cap   = 1'b1;
      S_INS:     cmd.ins_step = !stat.ins_done;
      S_INS_FIN: cmd.ins_fin  = 1'b1;
      S_DEL: begin
        cmd.del_step = !stat.del_done;
        cmd.del_fin  = stat.del_done;
      end
      S_DONE:    cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
    // a waiting result may leave in the same cycle a new one is loaded
    out_valid_nxt = (out_valid_r && out_stall) || cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/cleb_dp.sv */
// datapath: length and cursor registers, shift walk, text memory, result registers
// uses cleb_pkg and cleb_ram
module cleb_dp
  import cleb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cleb_cmd_t         cmd,
  output cleb_stat_t        stat,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_key,
  input  logic [ADDR_W-1:0] in_index,
  output logic              out_ok,
  output logic [7:0]        out_char_out,
  output logic [CNT_W-1:0]  out_length,
  output logic [CNT_W-1:0]  out_cursor
);

  logic [1:0]        func_r;
  logic [7:0]        key_r;
  logic [ADDR_W-1:0] index_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic              ok_r, ok_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic              out_ok_r;
  logic [7:0]        out_ch_r;
  logic [CNT_W-1:0]  out_len_r, out_cur_r;

  cleb_kind_t        kind;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  walk_dec;

  assign walk_dec = walk_r - CNT_W'(1);

  // classify the latched item
  always_comb begin
    kind = K_SIMPLE;
    unique case (func_r)
      FUNC_KEY: begin
        unique case (key_r) inside
          KEY_HOME, KEY_END, KEY_LEFT, KEY_RIGHT, KEY_NL: kind = K_SIMPLE;
          KEY_DEL: kind = (cursor_r != '0) ? K_DELETE : K_SIMPLE;
          default: kind = (fill_r < CNT_W'(BUF_DEPTH)) ? K_INSERT : K_SIMPLE;
        endcase
      end
      FUNC_READ: kind = ({1'b0, index_r} < fill_r) ? K_READ : K_SIMPLE;
      default:   kind = K_SIMPLE;
    endcase
  end

  assign stat.kind     = kind;
  assign stat.ins_done = (walk_r == cursor_r);
  assign stat.del_done = (walk_r == fill_r);

  always_comb begin
    fill_nxt      = fill_r;
    cursor_nxt    = cursor_r;
    walk_nxt      = walk_r;
    pend_v_nxt    = 1'b0;
    pend_addr_nxt = pend_addr_r;
    ok_nxt        = ok_r;
    ch_nxt        = ch_r;
    ram_raddr     = index_r;

    if (cmd.exec) begin
      ok_nxt = 1'b0;
      ch_nxt = 8'd0;
      unique case (kind)
        K_INSERT: begin
          walk_nxt = fill_r;
          ok_nxt   = 1'b1;
        end
        K_DELETE: begin
          walk_nxt = cursor_r;
          ok_nxt   = 1'b1;
        end
        K_READ: ok_nxt = 1'b0;
        default: begin
          if (func_r == FUNC_CLEAR) begin
            fill_nxt   = '0;
            cursor_nxt = '0;
            ok_nxt     = 1'b1;
          end else if (func_r == FUNC_KEY) begin
            unique case (key_r)
              KEY_HOME: begin
                cursor_nxt = '0;
                ok_nxt     = 1'b1;
              end
              KEY_END: begin
                cursor_nxt = fill_r;
                ok_nxt     = 1'b1;
              end
              KEY_LEFT: begin
                if (cursor_r != '0) begin
                  cursor_nxt = cursor_r - CNT_W'(1);
                  ok_nxt     = 1'b1;
                end
              end
              KEY_RIGHT: begin
                if (cursor_r < fill_r) begin
                  cursor_nxt = cursor_r + CNT_W'(1);
                  ok_nxt     = 1'b1;
                end
              end
              default: ok_nxt = 1'b0;
            endcase
          end
        end
      endcase
    end

    // insert walks down: read q-1, write it to q in the next cycle
    if (cmd.ins_step) begin
      ram_raddr     = walk_dec[ADDR_W-1:0];
      pend_v_nxt    = 1'b1;
      pend_addr_nxt = walk_r[ADDR_W-1:0];
      walk_nxt      = walk_dec;
    end

    // delete walks up: read q, write it to q-1 in the next cycle
    if (cmd.del_step) begin
      ram_raddr     = walk_r[ADDR_W-1:0];
      pend_v_nxt    = 1'b1;
      pend_addr_nxt = walk_dec[ADDR_W-1:0];
      walk_nxt      = walk_r + CNT_W'(1);
    end

    if (cmd.ins_fin) begin
      fill_nxt   = fill_r + CNT_W'(1);
      cursor_nxt = cursor_r + CNT_W'(1);
    end

    if (cmd.del_fin) begin
      fill_nxt   = fill_r - CNT_W'(1);
      cursor_nxt = cursor_r - CNT_W'(1);
    end

    if (cmd.rd_cap) begin
      ch_nxt = ram_rdata;
      ok_nxt = 1'b1;
    end
  end

  // pending shift write has priority; the key write only comes after the walk drains
  assign ram_we    = pend_v_r || cmd.ins_fin;
  assign ram_waddr = pend_v_r ? pend_addr_r : cursor_r[ADDR_W-1:0];
  assign ram_wdata = pend_v_r ? ram_rdata : key_r;

  cleb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cursor_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      cursor_r <= cursor_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r      <= walk_nxt;
    pend_addr_r <= pend_addr_nxt;
    ok_r        <= ok_nxt;
    ch_r        <= ch_nxt;
    if (cmd.latch) begin
      func_r  <= in_func;
      key_r   <= in_key;
      index_r <= in_index;
    end
    if (cmd.out_load) begin
      out_ok_r  <= ok_r;
      out_ch_r  <= ch_r;
      out_len_r <= fill_r;
      out_cur_r <= cursor_r;
    end
  end

  assign out_ok       = out_ok_r;
  assign out_char_out = out_ch_r;
  assign out_length   = out_len_r;
  assign out_cursor   = out_cur_r;

endmodule

/* dv/cursor_line_edit_buffer_top_test.sv */
// self-checking testbench for cursor_line_edit_buffer_top: directed, random, back-pressure
// and shift-walk tests against an in-bench model of the edit buffer
// depends on cleb_pkg and the cursor_line_edit_buffer_top rtl
module cursor_line_edit_buffer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cleb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 64;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_pattern_t;

  typedef struct {
    logic             ok;
    logic [7:0]       ch;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] cur;
  } edit_status_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [7:0]        in_key;
  logic [ADDR_W-1:0] in_index;
  logic              out_valid;
  logic              out_stall;
  logic              out_ok;
  logic [7:0]        out_char_out;
  logic [CNT_W-1:0]  out_length;
  logic [CNT_W-1:0]  out_cursor;

  // model of the buffer contents
  logic [7:0]       text_mem [BUF_DEPTH];
  logic [CNT_W-1:0] text_len = '0;
  logic [CNT_W-1:0] cur_pos = '0;

  edit_status_t status_q[$];
  int           mismatches = 0;
  int           cycle_cnt = 0;
  int           burst_left = 0;
  int           max_gap = 4;
  bit           hold_req = 1'b0;

  cursor_line_edit_buffer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_key       (in_key),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_char_out (out_char_out),
    .out_length   (out_length),
    .out_cursor   (out_cursor)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[cursor_line_edit_buffer_top] ERROR");
      $finish;
    end
  end

  function automatic logic apply_key(input logic [7:0] key);
    int   q;
    logic ok;
    ok = 1'b1;
    case (key)
      KEY_HOME: cur_pos = '0;
      KEY_END: cur_pos = text_len;
      KEY_LEFT: begin
        if (cur_pos == 0) ok = 1'b0;
        else cur_pos--;
      end
      KEY_RIGHT: begin
        if (cur_pos >= text_len) ok = 1'b0;
        else cur_pos++;
      end
      KEY_DEL: begin
        if (cur_pos == 0 || text_len == 0) begin
          ok = 1'b0;
        end else begin
          cur_pos--;
          for (q = cur_pos + 1; q < text_len; q++) text_mem[q-1] = text_mem[q];
          text_len--;
        end
      end
      KEY_NL: ok = 1'b0;
      default: begin
        // full buffer refuses the insert and the cursor stays put
        if (text_len >= BUF_DEPTH) begin
          ok = 1'b0;
        end else begin
          for (q = text_len; q > cur_pos; q--) text_mem[q] = text_mem[q-1];
          text_mem[cur_pos] = key;
          text_len++;
          cur_pos++;
        end
      end
    endcase
    return ok;
  endfunction

  task automatic predict_edit(input logic [1:0] func, input logic [7:0] key,
                              input logic [ADDR_W-1:0] index);
    edit_status_t st;
    st.ok = 1'b0;
    st.ch = 8'd0;
    case (func)
      FUNC_KEY: st.ok = apply_key(key);
      FUNC_READ: begin
        if (index < text_len) begin
          st.ch = text_mem[index];
          st.ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        text_len = '0;
        cur_pos = '0;
        st.ok = 1'b1;
      end
      default: ;
    endcase
    st.len = text_len;
    st.cur = cur_pos;
    status_q.push_back(st);
  endtask

  // any byte that is neither a command nor newline
  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == KEY_HOME || c == KEY_END || c == KEY_DEL || c == KEY_LEFT ||
        c == KEY_RIGHT || c == KEY_NL)
      c = 8'h61 + 8'($urandom_range(0, 25));
    return c;
  endfunction

  task automatic send_item(input logic [1:0] func, input logic [7:0] key,
                           input logic [ADDR_W-1:0] index);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    in_index <= index;
    do @(posedge clk); while (in_stall);
    predict_edit(func, key, index);
  endtask

  task automatic send_key(input logic [7:0] key);
    send_item(FUNC_KEY, key, ADDR_W'($urandom));
  endtask

  task automatic send_read(input logic [ADDR_W-1:0] index);
    send_item(FUNC_READ, 8'($urandom), index);
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // receiver: random stall patterns, plus a long hold-off on request
  initial begin : receiver
    int          hold_left;
    int          phase_left;
    rx_pattern_t rx_mode;
    hold_left = 0;
    phase_left = 0;
    rx_mode = RX_FLOW;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          rx_mode = rx_pattern_t'($urandom_range(0, 3));
          phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        case (rx_mode)
          RX_FLOW: out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= phase_left[0];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    edit_status_t st;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0d char=%0d len=%0d cur=%0d",
                 $time, out_ok, out_char_out, out_length, out_cursor);
        mismatches++;
      end else begin
        st = status_q.pop_front();
        report_field("ok", st.ok, out_ok);
        report_field("char_out", st.ch, out_char_out);
        report_field("length", st.len, out_length);
        report_field("cursor", st.cur, out_cursor);
      end
    end
  end

  task automatic test_directed();
    send_read(12'd0);          // read on empty buffer
    send_read(12'hFFF);
    send_key(KEY_LEFT);        // left at home
    send_key(KEY_RIGHT);       // right at end
    send_key(KEY_DEL);         // delete at home
    send_key(KEY_NL);
    send_item(FUNC_UNUSED, 8'hFF, 12'hFFF);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h78);
    send_key(KEY_HOME);
    send_key(KEY_RIGHT);
    send_key(KEY_LEFT);
    send_key(8'h6D);           // insert at home, everything shifts up
    send_key(KEY_RIGHT);
    send_key(KEY_DEL);         // delete in the middle
    send_key(KEY_END);
    send_key(KEY_RIGHT);
    send_key(KEY_DEL);         // delete at end
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd2);          // past the text
    send_item(FUNC_CLEAR, 8'h00, 12'd0);
    send_read(12'd0);
  endtask

  task automatic test_random();
    int pick;
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(FUNC_UNUSED, 8'($urandom), ADDR_W'($urandom));
      end else if (pick < 8) begin
        send_item(FUNC_CLEAR, 8'($urandom), ADDR_W'($urandom));
      end else if (pick < 28) begin
        if ($urandom_range(0, 4) == 0) send_read(ADDR_W'($urandom));
        else send_read(ADDR_W'($urandom_range(0, text_len)));
      end else if (pick < 55) begin
        case ($urandom_range(0, 6))
          0: send_key(KEY_HOME);
          1: send_key(KEY_END);
          2: send_key(KEY_LEFT);
          3: send_key(KEY_RIGHT);
          4: send_key(KEY_NL);
          default: send_key(KEY_DEL);
        endcase
      end else if (pick < 62) begin
        send_key(8'($urandom));
      end else begin
        send_key(rand_text_char());
      end
    end
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    max_gap = 0;
    hold_req = 1'b1;
    repeat (12) send_key(rand_text_char());
    send_read(12'd0);
    max_gap = 4;
  endtask

  // edits at home move the whole text one place through the memory
  task automatic test_shift_walk();
    max_gap = 1;
    send_item(FUNC_CLEAR, 8'h00, 12'd0);
    repeat (24) send_key(rand_text_char());
    send_key(KEY_HOME);
    send_key(rand_text_char());   // shifts the whole text up
    send_read(12'd0);
    send_read(12'd24);
    send_key(KEY_DEL);            // removes the first character, text shifts down
    send_read(12'd0);
    send_read(12'd23);
    send_read(12'd24);            // past the text
    send_key(KEY_END);
    send_key(KEY_DEL);
    send_key(8'hFF);
    send_read(12'd24);
    send_item(FUNC_CLEAR, 8'h00, 12'd0);
    max_gap = 4;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_KEY;
    in_key   = 8'd0;
    in_index = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random();
    test_backpressure();
    test_shift_walk();

    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (BUF_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("[cursor_line_edit_buffer_top] OK");
    end else begin
      $display("[cursor_line_edit_buffer_top] ERROR");
    end
    $finish;
  end

endmodule
